FILE: rtl/core/tap_gesture_recognizer_defines.svh
// assertion macros used by the tap gesture recognizer top level
`ifndef TAP_GESTURE_RECOGNIZER_DEFINES_SVH
`define TAP_GESTURE_RECOGNIZER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define TGR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tap gesture recognizer: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define TGR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tap gesture recognizer: next-cycle check failed");

`endif

FILE: rtl/core/tgr_pkg.sv
// shared types, codes and reset values for the tap gesture recognizer
package tgr_pkg;

   localparam int TIME_BITS     = 32;
   localparam int MOTION_BITS   = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int KIND_BITS     = 2;
   localparam int PHASE_BITS    = 2;

   localparam int COORD_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF = 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TAP_GAP    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_PRESS_TIME = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_MOTION     = 2'd2;

   // register reset values
   localparam logic [TIME_BITS-1:0]   MAX_TAP_GAP_RST    = 32'd500;
   localparam logic [TIME_BITS-1:0]   MAX_PRESS_TIME_RST = 32'd330;
   localparam logic [MOTION_BITS-1:0] MAX_MOTION_RST     = 16'd320;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_CLEAR      = 2'd0,
      PH_TOUCHED    = 2'd1,
      PH_REGISTERED = 2'd2,
      PH_FAILED     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_DOWN        = 2'd0,
      EV_UP          = 2'd1,
      EV_INTERRUPTED = 2'd2,
      EV_OTHER       = 2'd3
   } point_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_POSSIBLE  = 2'd0,
      KIND_STARTED   = 2'd1,
      KIND_CANCELLED = 2'd2
   } kind_type;

   // decisions for one event, handed from the decision logic to the datapath
   typedef struct packed {
      logic      emit;
      kind_type  kind;
      phase_type phase_nxt;
      logic      anchor_ld;
      logic      press_ld;
      logic      count_tap;
   } ctrl_type;

endpackage

FILE: rtl/core/tap_gesture_recognizer.sv
// top level of the multi-tap gesture recognizer
//
//   port group  direction  flow control      word
//   req_*       in         req_valid/stall   one touch event
//   rsp_*       out        rsp_valid/stall   one gesture result (zero or one per event)
//   csr_*       in         csr_we            register write, no read-back
//
// an event is registered on entry in the input register and decided there; its
// result is then written to the result register. one event per cycle is taken
// as long as the result register drains. the input register stalls only when it
// holds a result-producing event and the result register is full and stalled.
// reset is synchronous and active high; it restores the register defaults and
// clears the gesture phase, anchor, times and tap count.
module tap_gesture_recognizer #(
   parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF,
   parameter int COUNT_BITS = tgr_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // event channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_single_point,
   input  logic [1:0]                          req_point_phase,
   input  logic [tgr_pkg::TIME_BITS-1:0]       req_event_time,
   input  logic [COORD_BITS-1:0]               req_pos_x,
   input  logic [COORD_BITS-1:0]               req_pos_y,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tgr_pkg::KIND_BITS-1:0]       rsp_gesture_kind,
   output logic [COUNT_BITS-1:0]               rsp_tap_number,
   output logic [COORD_BITS-1:0]               rsp_anchor_x,
   output logic [COORD_BITS-1:0]               rsp_anchor_y,
   output logic [tgr_pkg::TIME_BITS-1:0]       rsp_gesture_time,
   // register write port
   input  logic                                csr_we,
   input  logic [tgr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tgr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   `include "tap_gesture_recognizer_defines.svh"

   // configuration registers
   logic [tgr_pkg::TIME_BITS-1:0]   max_tap_gap_ff;
   logic [tgr_pkg::TIME_BITS-1:0]   max_press_time_ff;
   logic [tgr_pkg::MOTION_BITS-1:0] max_motion_ff;

   // input register
   logic                            s1_valid_ff;
   logic                            s1_single_ff;
   logic [1:0]                      s1_point_ff;
   logic [tgr_pkg::TIME_BITS-1:0]   s1_time_ff;
   logic [COORD_BITS-1:0]           s1_x_ff;
   logic [COORD_BITS-1:0]           s1_y_ff;

   // gesture state
   tgr_pkg::phase_type              phase_ff;
   logic [COORD_BITS-1:0]           anchor_x_ff;
   logic [COORD_BITS-1:0]           anchor_y_ff;
   logic [tgr_pkg::TIME_BITS-1:0]   press_time_ff;
   logic [tgr_pkg::TIME_BITS-1:0]   last_tap_ff;
   logic [COUNT_BITS-1:0]           tap_count_ff;

   // result register
   logic                            out_valid_ff;
   logic                            out_valid_in;
   tgr_pkg::kind_type               out_kind_ff;
   logic [COUNT_BITS-1:0]           out_taps_ff;
   logic [COORD_BITS-1:0]           out_x_ff;
   logic [COORD_BITS-1:0]           out_y_ff;
   logic [tgr_pkg::TIME_BITS-1:0]   out_time_ff;

   tgr_pkg::ctrl_type               ctrl;
   logic                            out_free;
   logic                            s1_advance;
   logic                            req_take;
   logic [COUNT_BITS-1:0]           tap_count_in;

   // handshake
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!ctrl.emit || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   // saturating tap count
   assign tap_count_in = (&tap_count_ff) ? tap_count_ff : tap_count_ff + COUNT_BITS'(1);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tap_gap_ff    <= tgr_pkg::MAX_TAP_GAP_RST;
         max_press_time_ff <= tgr_pkg::MAX_PRESS_TIME_RST;
         max_motion_ff     <= tgr_pkg::MAX_MOTION_RST;
      end else if (csr_we) begin
         case (csr_index)
            tgr_pkg::CSR_MAX_TAP_GAP:    max_tap_gap_ff    <= csr_wdata;
            tgr_pkg::CSR_MAX_PRESS_TIME: max_press_time_ff <= csr_wdata;
            tgr_pkg::CSR_MAX_MOTION:
               max_motion_ff <= csr_wdata[tgr_pkg::MOTION_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_single_ff <= req_single_point;
         s1_point_ff  <= req_point_phase;
         s1_time_ff   <= req_event_time;
         s1_x_ff      <= req_pos_x;
         s1_y_ff      <= req_pos_y;
      end
   end

   tgr_decide #(
      .COORD_BITS (COORD_BITS)
   ) u_decide (
      .phase          (phase_ff),
      .single_point   (s1_single_ff),
      .point_phase    (s1_point_ff),
      .event_time     (s1_time_ff),
      .pos_x          (s1_x_ff),
      .pos_y          (s1_y_ff),
      .anchor_x       (anchor_x_ff),
      .anchor_y       (anchor_y_ff),
      .press_time     (press_time_ff),
      .last_tap_time  (last_tap_ff),
      .max_tap_gap    (max_tap_gap_ff),
      .max_press_time (max_press_time_ff),
      .max_motion     (max_motion_ff),
      .ctrl           (ctrl)
   );

   // gesture state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tgr_pkg::PH_CLEAR;
         anchor_x_ff   <= '0;
         anchor_y_ff   <= '0;
         press_time_ff <= '0;
         last_tap_ff   <= '0;
         tap_count_ff  <= '0;
      end else if (s1_advance) begin
         phase_ff <= ctrl.phase_nxt;
         if (ctrl.press_ld) begin
            press_time_ff <= s1_time_ff;
         end
         if (ctrl.anchor_ld) begin
            anchor_x_ff  <= s1_x_ff;
            anchor_y_ff  <= s1_y_ff;
            last_tap_ff  <= '0;
            tap_count_ff <= '0;
         end else if (ctrl.count_tap) begin
            last_tap_ff  <= s1_time_ff;
            tap_count_ff <= tap_count_in;
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance && ctrl.emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && ctrl.emit) begin
         out_kind_ff <= ctrl.kind;
         out_taps_ff <= ctrl.count_tap ? tap_count_in : '0;
         out_x_ff    <= ctrl.anchor_ld ? s1_x_ff : anchor_x_ff;
         out_y_ff    <= ctrl.anchor_ld ? s1_y_ff : anchor_y_ff;
         out_time_ff <= s1_time_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_gesture_kind = out_kind_ff;
   assign rsp_tap_number   = out_taps_ff;
   assign rsp_anchor_x     = out_x_ff;
   assign rsp_anchor_y     = out_y_ff;
   assign rsp_gesture_time = out_time_ff;

   // checks
   `TGR_ASSERT_IMP(a_possible_no_taps, rsp_valid && (rsp_gesture_kind == tgr_pkg::KIND_POSSIBLE), rsp_tap_number == '0)
   `TGR_ASSERT_NXT(a_tap_registers, s1_advance && ctrl.count_tap, phase_ff == tgr_pkg::PH_REGISTERED)
   `TGR_ASSERT_NXT(a_multi_point_fails, s1_advance && !s1_single_ff, phase_ff == tgr_pkg::PH_FAILED)
   `TGR_ASSERT_NXT(a_held_event_kept, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_time_ff))

endmodule

FILE: rtl/core/tgr_decide.sv
// per-event decision logic: time windows, motion test and phase transitions
module tgr_decide #(
   parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF
) (
   input  tgr_pkg::phase_type                phase,
   input  logic                              single_point,
   input  logic [1:0]                        point_phase,
   input  logic [tgr_pkg::TIME_BITS-1:0]     event_time,
   input  logic [COORD_BITS-1:0]             pos_x,
   input  logic [COORD_BITS-1:0]             pos_y,
   input  logic [COORD_BITS-1:0]             anchor_x,
   input  logic [COORD_BITS-1:0]             anchor_y,
   input  logic [tgr_pkg::TIME_BITS-1:0]     press_time,
   input  logic [tgr_pkg::TIME_BITS-1:0]     last_tap_time,
   input  logic [tgr_pkg::TIME_BITS-1:0]     max_tap_gap,
   input  logic [tgr_pkg::TIME_BITS-1:0]     max_press_time,
   input  logic [tgr_pkg::MOTION_BITS-1:0]   max_motion,
   output tgr_pkg::ctrl_type                 ctrl
);

   localparam int CMP_BITS = (COORD_BITS > tgr_pkg::MOTION_BITS) ?
                             COORD_BITS : tgr_pkg::MOTION_BITS;

   logic [COORD_BITS-1:0]            dx;
   logic [COORD_BITS-1:0]            dy;
   logic                             far;
   logic [tgr_pkg::TIME_BITS-1:0]    press_dt;
   logic [tgr_pkg::TIME_BITS-1:0]    gap_dt;
   logic                             quick;
   logic                             gap_ok;
   tgr_pkg::point_type               ev;

   // per-axis distance from the anchor
   assign dx  = (pos_x > anchor_x) ? (pos_x - anchor_x) : (anchor_x - pos_x);
   assign dy  = (pos_y > anchor_y) ? (pos_y - anchor_y) : (anchor_y - pos_y);
   assign far = (CMP_BITS'(dx) > CMP_BITS'(max_motion)) ||
                (CMP_BITS'(dy) > CMP_BITS'(max_motion));

   // wrapping time windows
   assign press_dt = event_time - press_time;
   assign gap_dt   = event_time - last_tap_time;
   assign quick    = press_dt < max_press_time;
   assign gap_ok   = gap_dt <= max_tap_gap;

   assign ev = tgr_pkg::point_type'(point_phase);

   // phase transitions
   always_comb begin
      ctrl.emit      = 1'b0;
      ctrl.kind      = tgr_pkg::KIND_POSSIBLE;
      ctrl.phase_nxt = phase;
      ctrl.anchor_ld = 1'b0;
      ctrl.press_ld  = 1'b0;
      ctrl.count_tap = 1'b0;
      if (!single_point) begin
         ctrl.phase_nxt = tgr_pkg::PH_FAILED;
      end else begin
         case (phase)
            tgr_pkg::PH_CLEAR: begin
               if (ev == tgr_pkg::EV_DOWN) begin
                  ctrl.emit      = 1'b1;
                  ctrl.anchor_ld = 1'b1;
                  ctrl.press_ld  = 1'b1;
                  ctrl.phase_nxt = tgr_pkg::PH_TOUCHED;
               end
            end
            tgr_pkg::PH_TOUCHED: begin
               if (ev == tgr_pkg::EV_UP) begin
                  if (quick) begin
                     ctrl.emit      = 1'b1;
                     ctrl.count_tap = 1'b1;
                     ctrl.kind      = far ? tgr_pkg::KIND_CANCELLED : tgr_pkg::KIND_STARTED;
                     ctrl.phase_nxt = tgr_pkg::PH_REGISTERED;
                  end else begin
                     ctrl.phase_nxt = tgr_pkg::PH_CLEAR;
                  end
               end else if (ev == tgr_pkg::EV_INTERRUPTED) begin
                  ctrl.phase_nxt = tgr_pkg::PH_CLEAR;
               end
            end
            tgr_pkg::PH_REGISTERED: begin
               if (ev == tgr_pkg::EV_UP) begin
                  if (quick && !far) begin
                     ctrl.emit      = 1'b1;
                     ctrl.count_tap = 1'b1;
                     ctrl.kind      = tgr_pkg::KIND_STARTED;
                  end else begin
                     ctrl.phase_nxt = tgr_pkg::PH_CLEAR;
                  end
               end else if (ev == tgr_pkg::EV_DOWN) begin
                  ctrl.emit     = 1'b1;
                  ctrl.press_ld = 1'b1;
                  // a distant or late press starts a new gesture
                  if (far || !gap_ok) begin
                     ctrl.anchor_ld = 1'b1;
                     ctrl.phase_nxt = tgr_pkg::PH_TOUCHED;
                  end
               end
            end
            default: begin
               ctrl.phase_nxt = tgr_pkg::PH_CLEAR;
            end
         endcase
      end
   end

endmodule
